[hw/rtl/thsp_pkg.sv]
// Package with the segment tables, scaling constants and shared types of the setpoint converter.
`default_nettype none

package thsp_pkg;

    localparam int unsigned SegCount = 9;
    localparam int unsigned SegIdxW = 4;
    localparam int unsigned CentiW = 13;
    localparam int unsigned SlopeW = 10;
    localparam int unsigned OffsW = 22;
    localparam int unsigned NumW = 24;
    localparam int unsigned ScaledW = 26;
    localparam int unsigned RecipW = 27;
    localparam int unsigned QuotW = 14;
    localparam int unsigned CodeW = 12;

    localparam logic signed [15:0] CentiLow = 16'sd1000;
    localparam logic signed [15:0] CentiHigh = 16'sd5000;
    localparam logic [CentiW-1:0] SegFirst = 13'd1000;
    localparam logic [CentiW-1:0] SegStep = 13'd500;

    localparam logic [8:0] CodeMul = 9'd273;
    localparam int unsigned CodeShift = 5;
    localparam int unsigned RecipShift = 39;
    localparam logic [RecipW-1:0] RecipM =
        RecipW'(((64'd1 << RecipShift) + 64'd6874) / 64'd6875);
    localparam logic [CodeW-1:0] CodeMax = 12'd4095;

    typedef logic [SegIdxW-1:0] t_seg_idx;

    typedef logic [SlopeW-1:0] t_slope_tab [SegCount];
    typedef logic [OffsW-1:0] t_offs_tab [SegCount];

    localparam t_slope_tab SegSlope = '{
        10'd841, 10'd645, 10'd499, 10'd389, 10'd305,
        10'd241, 10'd191, 10'd153, 10'd123
    };

    localparam t_offs_tab SegOffs100 = '{
        22'd2834300, 22'd2540900, 22'd2248500, 22'd1972500, 22'd1721700,
        22'd1496300, 22'd1298700, 22'd1125900, 22'd975900
    };

    typedef struct packed {
        logic en3;
        logic en4;
    } t_scale_ctl;

endpackage

`default_nettype wire

[hw/rtl/thsp_seg.sv]
// First stage: clamps the setpoint and finds its 5-degree segment.
`default_nettype none

module thsp_seg
    import thsp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic signed [15:0] i_temp_centi,
    output logic [CentiW-1:0]      o_centi,
    output t_seg_idx               o_seg
);

    logic [CentiW-1:0] n_centi;
    t_seg_idx          n_seg;
    logic [CentiW-1:0] r_centi;
    t_seg_idx          r_seg;

    always_comb begin
        if (i_temp_centi < CentiLow) begin
            n_centi = CentiW'(CentiLow);
        end else if (i_temp_centi > CentiHigh) begin
            n_centi = CentiW'(CentiHigh);
        end else begin
            n_centi = i_temp_centi[CentiW-1:0];
        end
        n_seg = '0;
        for (int j = 1; j < SegCount; j++) begin
            if (n_centi >= SegFirst + CentiW'(j) * SegStep) begin
                n_seg = n_seg + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_centi <= n_centi;
            r_seg <= n_seg;
        end
    end

    assign o_centi = r_centi;
    assign o_seg = r_seg;

endmodule

`default_nettype wire

[hw/rtl/thsp_interp.sv]
// Second stage: looks up slope and intercept and forms 100 times the resistance.
`default_nettype none

module thsp_interp
    import thsp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [CentiW-1:0] i_centi,
    input  wire t_seg_idx          i_seg,
    output logic signed [NumW-1:0] o_num
);

    logic [SlopeW-1:0]        slope;
    logic [OffsW-1:0]         offs;
    logic [SlopeW+CentiW-1:0] prod;
    logic signed [NumW-1:0]   n_num;
    logic signed [NumW-1:0]   r_num;

    always_comb begin
        if (i_seg < SegIdxW'(SegCount)) begin
            slope = SegSlope[i_seg];
            offs = SegOffs100[i_seg];
        end else begin
            slope = SegSlope[SegCount-1];
            offs = SegOffs100[SegCount-1];
        end
        prod = slope * i_centi;
        n_num = signed'(NumW'(offs)) - signed'(NumW'(prod));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
        end
    end

    assign o_num = r_num;

endmodule

`default_nettype wire

[hw/rtl/thsp_scale.sv]
// Third and fourth stages: scales the resistance to a DAC code by reciprocal multiplication.
`default_nettype none

module thsp_scale
    import thsp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_scale_ctl          i_ctl,
    input  wire logic signed [NumW-1:0] i_num,
    output logic [CodeW-1:0]         o_dac_code
);

    logic [OffsW+8:0]          wide;
    logic [ScaledW-1:0]        r_scaled;
    logic                      r_pos;
    logic [ScaledW+RecipW-1:0] quot_prod;
    logic [QuotW-1:0]          quot;
    logic [CodeW-1:0]          n_code;
    logic [CodeW-1:0]          r_code;

    always_comb begin
        wide = i_num[OffsW-1:0] * CodeMul;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_scaled <= ScaledW'(wide >> CodeShift);
            r_pos <= (i_num > 0);
        end
    end

    always_comb begin
        quot_prod = r_scaled * RecipM;
        quot = quot_prod[RecipShift +: QuotW];
        if (!r_pos) begin
            n_code = '0;
        end else if (quot > QuotW'(CodeMax)) begin
            n_code = CodeMax;
        end else begin
            n_code = quot[CodeW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_code <= n_code;
        end
    end

    assign o_dac_code = r_code;

endmodule

`default_nettype wire

[hw/rtl/thermistor_setpoint_to_dac_code.sv]
// Top level of the thermistor setpoint to DAC code converter.
// Each item is a setpoint in hundredths of a degree, clamped to 10.00 to 50.00 degrees,
// and gives one 12-bit DAC code. The converter is a four-stage pipeline (clamp and
// segment, interpolation multiply, code scaling multiply, reciprocal multiply), and
// one item is taken every cycle unless a stall at the output has backed up to the
// first stage. A stall at the output holds each stage whose item cannot move on,
// while items behind it close up into empty stages.
`default_nettype none

module thermistor_setpoint_to_dac_code
    import thsp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic signed [15:0] i_temp_centi,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [11:0]            o_dac_code
);

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    logic [CentiW-1:0]      centi;
    t_seg_idx               seg;
    logic signed [NumW-1:0] num;
    t_scale_ctl             scale_ctl;

    assign en4 = !r_v4 || i_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign scale_ctl.en3 = en3;
    assign scale_ctl.en4 = en4;

    thsp_seg u_seg (
        .i_clk        (i_clk),
        .i_en         (en1),
        .i_temp_centi (i_temp_centi),
        .o_centi      (centi),
        .o_seg        (seg)
    );

    thsp_interp u_interp (
        .i_clk   (i_clk),
        .i_en    (en2),
        .i_centi (centi),
        .i_seg   (seg),
        .o_num   (num)
    );

    thsp_scale u_scale (
        .i_clk      (i_clk),
        .i_ctl      (scale_ctl),
        .i_num      (num),
        .o_dac_code (o_dac_code)
    );

    assign o_ready = en1;
    assign o_valid = r_v4;

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench for the setpoint to DAC code converter, with a queue-fed driver and a monitor.
`default_nettype none

module tb;
    import thsp_pkg::*;

    localparam int unsigned CycleLimit = 250000;
    localparam int unsigned RandomItems = 1650;
    localparam int unsigned IdlePct = 21;
    localparam int unsigned CalmFirst = 700;
    localparam int unsigned CalmLast = 1000;

    localparam int unsigned NtcOhms [23] = '{
        55786, 42582, 32773, 25456, 19931, 15725, 12497, 10000,
        8055, 6528, 5323, 4365, 3599, 2983, 2486, 2082,
        1753, 1482, 1258, 1073, 919, 790, 682
    };

    typedef struct {
        logic signed [15:0] setpoint;
        logic [CodeW-1:0]   code;
    } t_code_exp;

    logic                i_clk;
    logic                i_rst_n;
    logic                tb_valid;
    logic                dut_ready;
    logic signed [15:0]  tb_temp;
    logic                dut_valid;
    logic                tb_ready;
    logic [11:0]         dut_code;

    logic signed [15:0]  setpoint_q [$];
    t_code_exp           code_q [$];
    logic                in_took;
    int unsigned         n_issued;
    int unsigned         n_errors;
    int unsigned         n_cycles;

    thermistor_setpoint_to_dac_code dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (tb_valid),
        .o_ready      (dut_ready),
        .i_temp_centi (tb_temp),
        .o_valid      (dut_valid),
        .i_ready      (tb_ready),
        .o_dac_code   (dut_code)
    );

    function automatic logic [CodeW-1:0] dac_code_for(input logic signed [15:0] centi);
        longint c;
        longint seg;
        longint r_lo;
        longint r_hi;
        longint slope;
        longint offs;
        longint num;
        c = centi;
        if (c < 1000) begin
            c = 1000;
        end else if (c > 5000) begin
            c = 5000;
        end
        seg = c / 500 + 2;
        if (seg > 21) begin
            seg = 21;
        end
        r_lo = NtcOhms[seg];
        r_hi = NtcOhms[seg + 1];
        slope = (r_lo - r_hi) / 5;
        offs = r_lo * (seg - 1) - r_hi * (seg - 2);
        num = offs * 100 - slope * c;
        if (num <= 0) begin
            return '0;
        end
        num = (num * 4095) / 3300000;
        if (num > 4095) begin
            return CodeMax;
        end
        return num[CodeW-1:0];
    endfunction

    function automatic logic signed [15:0] random_setpoint();
        int unsigned pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 65) begin
            v = $urandom_range(5200, 800);
        end else if (pick < 80) begin
            v = 1000 + 500 * $urandom_range(8) + $urandom_range(2) - 1;
        end else begin
            v = $urandom;
        end
        return v[15:0];
    endfunction

    always begin
        #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_code_exp want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= tb_valid && dut_ready;
            if (tb_valid && dut_ready) begin
                want.setpoint = tb_temp;
                want.code = dac_code_for(tb_temp);
                code_q.push_back(want);
            end
            if (dut_valid && tb_ready) begin
                if (code_q.size() == 0) begin
                    $display("%0t: unexpected dac_code item %0d", $time, dut_code);
                    n_errors++;
                end else begin
                    want = code_q.pop_front();
                    if (dut_code !== want.code) begin
                        $display("%0t: dac_code for setpoint %0d: expected %0d, actual %0d",
                                 $time, want.setpoint, want.code, dut_code);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        logic calm;
        logic next_valid;
        logic signed [15:0] next_temp;
        if (i_rst_n) begin
            calm = (n_issued >= CalmFirst) && (n_issued < CalmLast);
            next_valid = tb_valid;
            next_temp = tb_temp;
            if (!tb_valid || in_took) begin
                if (setpoint_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
                    next_valid = 1'b1;
                    next_temp = setpoint_q.pop_front();
                    n_issued <= n_issued + 1;
                end else begin
                    next_valid = 1'b0;
                end
            end
            tb_valid <= next_valid;
            tb_temp <= next_temp;
            tb_ready <= calm || ($urandom_range(99) >= IdlePct);
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        tb_valid = 1'b0;
        tb_temp = '0;
        tb_ready = 1'b0;
        in_took = 1'b0;
        n_issued = 0;
        n_errors = 0;
        n_cycles = 0;

        setpoint_q = '{
            -16'sd32768, 16'sd32767, -16'sd1, 16'sd0, -16'sd1000, 16'sd999,
            16'sd1000, 16'sd1001, 16'sd1499, 16'sd1500, 16'sd2000, 16'sd2500,
            16'sd3000, 16'sd3500, 16'sd4000, 16'sd4499, 16'sd4500, 16'sd4501,
            16'sd4999, 16'sd5000, 16'sd5001, 16'sd5500, -16'sd21846, 16'sd21845
        };
        for (int i = 0; i < RandomItems; i++) begin
            setpoint_q.push_back(random_setpoint());
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (setpoint_q.size() != 0 || tb_valid || code_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (n_errors == 0 && code_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
